[rtl/chus_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chus_pkg
// Shared constants and types of the counter hash uniform sampler.
// ----------------------------------------------------------------------------
package chus_pkg;

   localparam int WORD_W      = 64;
   localparam int HALF_W      = 32;
   localparam int FIELD_SLOTS = 4;   // scalar and axis fields on the request
   localparam int COUNT_W     = 3;

   localparam int DEF_MAX_SCALARS = 4;
   localparam int DEF_MAX_AXES    = 4;

   // finaliser constants
   localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;
   localparam int SHIFT_A = 30;
   localparam int SHIFT_B = 27;
   localparam int SHIFT_C = 31;

   localparam int FRAC_W   = 53;
   localparam int FRAC_LSB = WORD_W - FRAC_W;

   // request tdata layout, lowest field first
   localparam int SCOUNT_LSB = 0;
   localparam int SCALAR_LSB = SCOUNT_LSB + COUNT_W;
   localparam int ACOUNT_LSB = SCALAR_LSB + FIELD_SLOTS * WORD_W;
   localparam int AXIS_LSB   = ACOUNT_LSB + COUNT_W;
   localparam int REQ_BITS   = AXIS_LSB + FIELD_SLOTS * WORD_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_W = 2;
   localparam int TUSER_FIRST = 0;
   localparam int TUSER_CLEAR = 1;

   // response tdata layout
   localparam int RSP_BITS    = FRAC_W + WORD_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // configuration registers
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEED       = 1'b0,
      CSR_FOLD_COUNT = 1'b1
   } csr_index_type;

endpackage

[rtl/chus_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chus_mul
// Xor-shift then 64-bit multiply by a constant, low 64 bits kept, built
// from 32-bit partial products over three register stages.
// ----------------------------------------------------------------------------
module chus_mul #(
   parameter int                              SHIFT  = chus_pkg::SHIFT_A,
   parameter logic [chus_pkg::WORD_W-1:0]     MULT   = chus_pkg::MIX_MUL_A,
   parameter int                              SIDE_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [chus_pkg::WORD_W-1:0] in_data,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [chus_pkg::WORD_W-1:0] out_data,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int HW = chus_pkg::HALF_W;
   localparam int WW = chus_pkg::WORD_W;
   localparam logic [HW-1:0] MULT_LO = MULT[HW-1:0];
   localparam logic [HW-1:0] MULT_HI = MULT[WW-1:HW];

   logic              v1_ff, v2_ff, v3_ff;
   logic [WW-1:0]     z1_ff, z1_in;
   logic [WW-1:0]     p1_ff, p1_in;
   logic [SIDE_W-1:0] s1_ff, s2_ff, s3_ff;
   logic [HW-1:0]     zl2_ff;
   logic [WW-1:0]     p2_ff;
   logic [HW-1:0]     q2_ff, q2_in;
   logic [HW-1:0]     r3;
   logic [WW-1:0]     res_ff, res_in;

   // stage 1: xor-shift, low by low product
   assign z1_in = in_data ^ (in_data >> SHIFT);
   assign p1_in = WW'(z1_in[HW-1:0]) * WW'(MULT_LO);
   // stage 2: high by low cross term, low half only
   assign q2_in = z1_ff[WW-1:HW] * MULT_LO;
   // stage 3: low by high cross term and final sum
   assign r3     = zl2_ff * MULT_HI;
   assign res_in = p2_ff + {q2_ff + r3, {HW{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z1_ff  <= z1_in;
         p1_ff  <= p1_in;
         s1_ff  <= in_side;
         zl2_ff <= z1_ff[HW-1:0];
         p2_ff  <= p1_ff;
         q2_ff  <= q2_in;
         s2_ff  <= s1_ff;
         res_ff <= res_in;
         s3_ff  <= s2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = res_ff;
   assign out_side  = s3_ff;

endmodule

[rtl/chus_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chus_cell
// One fold step of the hash chain: h becomes mix(h ^ word) when the slot is
// enabled, otherwise h passes on unchanged. Seven register stages.
// ----------------------------------------------------------------------------
module chus_cell #(
   parameter int N    = 9,
   parameter int SLOT = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [chus_pkg::WORD_W-1:0]         in_hash,
   input  logic [chus_pkg::WORD_W-1:0]         in_count,
   input  logic [N-1:0]                        in_en,
   input  logic [N-1:0][chus_pkg::WORD_W-1:0]  in_words,
   output logic                                out_valid,
   output logic [chus_pkg::WORD_W-1:0]         out_hash,
   output logic [chus_pkg::WORD_W-1:0]         out_count,
   output logic [N-1:0]                        out_en,
   output logic [N-1:0][chus_pkg::WORD_W-1:0]  out_words
);

   localparam int WW     = chus_pkg::WORD_W;
   localparam int SIDE_W = 2 * WW + N + N * WW;

   logic [SIDE_W-1:0] side_a, side_b, side_c;
   logic              va, vb;
   logic [WW-1:0]     ya, yb;
   logic [WW-1:0]     f;
   logic [WW-1:0]     c_hash, c_count;
   logic [N-1:0]      c_en;
   logic [N-1:0][WW-1:0] c_words;

   logic              valid_ff;
   logic [WW-1:0]     hash_ff, hash_in;
   logic [WW-1:0]     count_ff;
   logic [N-1:0]      en_ff;
   logic [N-1:0][WW-1:0] words_ff;

   assign side_a = {in_count, in_en, in_words, in_hash};

   chus_mul #(
      .SHIFT  (chus_pkg::SHIFT_A),
      .MULT   (chus_pkg::MIX_MUL_A),
      .SIDE_W (SIDE_W)
   ) u_mul_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_data   (in_hash ^ in_words[SLOT]),
      .in_side   (side_a),
      .out_valid (va),
      .out_data  (ya),
      .out_side  (side_b)
   );

   chus_mul #(
      .SHIFT  (chus_pkg::SHIFT_B),
      .MULT   (chus_pkg::MIX_MUL_B),
      .SIDE_W (SIDE_W)
   ) u_mul_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (va),
      .in_data   (ya),
      .in_side   (side_b),
      .out_valid (vb),
      .out_data  (yb),
      .out_side  (side_c)
   );

   assign {c_count, c_en, c_words, c_hash} = side_c;

   assign f       = yb ^ (yb >> chus_pkg::SHIFT_C);
   // disabled slot keeps the hash it was handed
   assign hash_in = c_en[SLOT] ? f : c_hash;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= vb;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hash_ff  <= hash_in;
         count_ff <= c_count;
         en_ff    <= c_en;
         words_ff <= c_words;
      end
   end

   assign out_valid = valid_ff;
   assign out_hash  = hash_ff;
   assign out_count = count_ff;
   assign out_en    = en_ff;
   assign out_words = words_ff;

endmodule

[rtl/counter_hash_uniform_sampler.sv]
`timescale 1ns / 1ps
// Structure: a chain of (min(MAX_SCALARS,4) + 1 + min(MAX_AXES,4)) fold cells
//   between request transfer and response valid.
// Throughput: one item per cycle while the response side takes transfers;
//   the whole cell chain holds when a response waits.
// Reset: synchronous, clears seed, the counter-fold flag, both call counters
//   and all stage valid bits.
// ----------------------------------------------------------------------------
// counter_hash_uniform_sampler
// Uniform sample from a chain of SplitMix64 finaliser steps over seed,
// scalar words, optional call counter and axis values.
// ----------------------------------------------------------------------------
module counter_hash_uniform_sampler #(
   parameter int MAX_SCALARS = chus_pkg::DEF_MAX_SCALARS,
   parameter int MAX_AXES    = chus_pkg::DEF_MAX_AXES
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // scalar_count, scalar_0..3, axis_count, axis_value_0..3, zero pad
   input  logic [chus_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // first_of_call, clear_counter
   input  logic [chus_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // response
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fraction, counter_value, zero pad
   output logic [chus_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                                csr_we,
   input  logic [chus_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [chus_pkg::WORD_W-1:0]         csr_wdata
);

   localparam int WW  = chus_pkg::WORD_W;
   localparam int CW  = chus_pkg::COUNT_W;
   localparam int FS  = chus_pkg::FIELD_SLOTS;
   localparam int NSC = (MAX_SCALARS < FS) ? MAX_SCALARS : FS;
   localparam int NAX = (MAX_AXES < FS) ? MAX_AXES : FS;
   localparam int N   = NSC + 1 + NAX;
   localparam int CTR_SLOT = NSC;

   logic [WW-1:0] seed_ff;
   logic          fold_count_ff;
   logic [WW-1:0] call_count_ff, call_count_in;
   logic [WW-1:0] latched_ff, latched_in;
   logic [WW-1:0] cleared;

   logic advance;
   logic req_xfer;

   logic [CW-1:0]        scalar_count, axis_count;
   logic [FS-1:0][WW-1:0] scalars, axes;
   logic                 first_of_call, clear_counter;

   logic [N-1:0]         slot_en;
   logic [N-1:0][WW-1:0] slot_words;

   logic [N:0]                 ch_valid;
   logic [N:0][WW-1:0]         ch_hash;
   logic [N:0][WW-1:0]         ch_count;
   logic [N:0][N-1:0]          ch_en;
   logic [N:0][N-1:0][WW-1:0]  ch_words;

   assign scalar_count  = req_tdata[chus_pkg::SCOUNT_LSB +: CW];
   assign scalars       = req_tdata[chus_pkg::SCALAR_LSB +: FS * WW];
   assign axis_count    = req_tdata[chus_pkg::ACOUNT_LSB +: CW];
   assign axes          = req_tdata[chus_pkg::AXIS_LSB +: FS * WW];
   assign first_of_call = req_tuser[chus_pkg::TUSER_FIRST];
   assign clear_counter = req_tuser[chus_pkg::TUSER_CLEAR];

   // whole chain moves together; it holds only while a response waits
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign req_xfer   = req_tvalid && advance;

   // call counter update for the item on the request side
   always_comb begin
      cleared       = clear_counter ? '0 : call_count_ff;
      latched_in    = latched_ff;
      call_count_in = cleared;
      if (first_of_call) begin
         latched_in = cleared;
         if (fold_count_ff) begin
            call_count_in = cleared + WW'(1);
         end
      end
   end

   // a count above the number of slots saturates: only existing slots compare
   always_comb begin
      for (int i = 0; i < NSC; i++) begin
         slot_en[i]    = scalar_count > CW'(i);
         slot_words[i] = scalars[i];
      end
      slot_en[CTR_SLOT]    = fold_count_ff;
      slot_words[CTR_SLOT] = latched_in;
      for (int i = 0; i < NAX; i++) begin
         slot_en[CTR_SLOT + 1 + i]    = axis_count > CW'(i);
         slot_words[CTR_SLOT + 1 + i] = axes[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff        <= '0;
         fold_count_ff  <= 1'b0;
         call_count_ff  <= '0;
         latched_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (chus_pkg::csr_index_type'(csr_index))
               chus_pkg::CSR_SEED:       seed_ff       <= csr_wdata;
               chus_pkg::CSR_FOLD_COUNT: fold_count_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_xfer) begin
            call_count_ff <= call_count_in;
            latched_ff    <= latched_in;
         end
      end
   end

   assign ch_valid[0] = req_tvalid;
   assign ch_hash[0]  = seed_ff;
   assign ch_count[0] = call_count_in;
   assign ch_en[0]    = slot_en;
   assign ch_words[0] = slot_words;

   for (genvar k = 0; k < N; k++) begin : g_cell
      chus_cell #(
         .N    (N),
         .SLOT (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (ch_valid[k]),
         .in_hash   (ch_hash[k]),
         .in_count  (ch_count[k]),
         .in_en     (ch_en[k]),
         .in_words  (ch_words[k]),
         .out_valid (ch_valid[k+1]),
         .out_hash  (ch_hash[k+1]),
         .out_count (ch_count[k+1]),
         .out_en    (ch_en[k+1]),
         .out_words (ch_words[k+1])
      );
   end

   assign rsp_tvalid = ch_valid[N];
   assign rsp_tdata  = {{(chus_pkg::RSP_TDATA_W - chus_pkg::RSP_BITS){1'b0}},
                        ch_count[N],
                        ch_hash[N][WW-1:chus_pkg::FRAC_LSB]};

endmodule

[rtl/chus_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chus_checker
// Port-level checks on the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module chus_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [chus_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   // a held response keeps its value
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // the chain stops as a whole: no request transfer under a stalled response
   a_no_take_when_stalled : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   // nothing in flight after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // padding above the counter stays zero
   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[chus_pkg::RSP_TDATA_W-1:chus_pkg::RSP_BITS] == '0)
      else $error("response padding not zero");

endmodule

bind counter_hash_uniform_sampler chus_checker u_chus_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
